// ----- design/length_prefixed_nal_to_start_code_unit_assert.svh -----
// Assertion macros for the length-prefixed NAL to start code unit.
`ifndef LENGTH_PREFIXED_NAL_TO_START_CODE_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_NAL_TO_START_CODE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LPNSC_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LPNSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LPNSC_ASSERT_IMPLY(lbl, ante, cons)
`define LPNSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/lpnsc_pkg.sv -----
`timescale 1ns / 1ps

package lpnsc_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 32;
   localparam int START_CODE_LEN       = 4;
   localparam int QUEUE_DEPTH          = 4;
   localparam int CSR_DATA_WIDTH       = 32;
   localparam int COUNT_WIDTH          = 32;

   localparam logic [7:0] START_CODE [START_CODE_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

   localparam logic CSR_LENGTH_FIELD_SIZE = 1'b0;
   localparam logic CSR_OUTPUT_CAPACITY   = 1'b1;

   localparam logic [2:0]  SIZE_MIN       = 3'd1;
   localparam logic [2:0]  SIZE_MAX       = 3'd4;
   localparam logic [2:0]  SIZE_RESET     = 3'd4;
   localparam logic [31:0] CAPACITY_RESET = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'b00,
      CMD_START = 2'b01,
      CMD_END   = 2'b10
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [7:0]        data;
      logic              sample_end;
      logic              sample_ok;
      logic [COUNT_WIDTH-1:0] total;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

// ----- design/length_prefixed_nal_to_start_code_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | Contents
// req_     | in        | tdata: in_byte; tlast: sample_last
// rsp_     | out       | tdata: out_byte, run_last, sample_ok, total_length; tuser: byte_valid;
//          |           | tlast: sample_end
// csr_     | in        | index 0 length_field_size, index 1 output_capacity
// One input byte is taken per cycle while the four-entry command queue has room.
// Payload bytes and sample-end reports leave one per cycle while the result port is ready;
// a length field that completes a NAL header makes the back end send the start code first.
// Reset is synchronous and active high and clears the sample state and the queue.
// A stalled result port backs up the queue, and a full queue stalls the input.

`include "length_prefixed_nal_to_start_code_unit_assert.svh"

module length_prefixed_nal_to_start_code_unit #(
   parameter int LENGTH_WIDTH = lpnsc_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] in_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] out_byte, [8] run_last, [9] sample_ok, [41:10] total_length
   output logic [47:0]                          rsp_tdata,
   output logic                                 rsp_tuser,  // [0] byte_valid
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [lpnsc_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   logic                        accept;
   logic                        cmd_valid;
   lpnsc_pkg::cmd_type          cmd;
   lpnsc_pkg::cmd_type          head_cmd;
   lpnsc_pkg::queue_status_type status;
   logic                        pop;

   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;

   lpnsc_front #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .sample_last (req_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   lpnsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && cmd_valid),
      .push_cmd (cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (status)
   );

   lpnsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `LPNSC_ASSERT_IMPLY(a_empty_only_at_end, rsp_tvalid && !rsp_tuser, rsp_tlast)
   `LPNSC_ASSERT_IMPLY(a_total_only_on_ok_end, rsp_tvalid && rsp_tdata[41:10] != 32'd0, rsp_tlast && rsp_tdata[9])
   `LPNSC_ASSERT_IMPLY(a_end_is_run_last, rsp_tvalid && rsp_tlast, rsp_tdata[8])
   `LPNSC_ASSERT_NEXT(a_full_queue_stalls, status.full && !pop, !req_tready)

endmodule

// ----- design/lpnsc_front.sv -----
`timescale 1ns / 1ps

module lpnsc_front #(
   parameter int LENGTH_WIDTH = lpnsc_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [7:0]                            in_byte,
   input  logic                                  sample_last,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [lpnsc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output logic                                  cmd_valid,
   output lpnsc_pkg::cmd_type                    cmd
);

   localparam int CW = lpnsc_pkg::COUNT_WIDTH;

   logic [2:0]              size_ff;
   logic [CW-1:0]           capacity_ff;
   logic [LENGTH_WIDTH-1:0] left_ff, left_in;
   logic [LENGTH_WIDTH-1:0] acc_ff, acc_in;
   logic [2:0]              seen_ff, seen_in;
   logic [CW-1:0]           bytes_out_ff, bytes_out_in;
   logic                    failed_ff, failed_in;

   logic [2:0]              size_eff;
   logic [LENGTH_WIDTH-1:0] left_dec;
   logic [LENGTH_WIDTH-1:0] acc_next;
   logic [2:0]              seen_inc;
   logic [CW+1:0]           need;
   logic                    fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= lpnsc_pkg::SIZE_RESET;
         capacity_ff <= lpnsc_pkg::CAPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lpnsc_pkg::CSR_LENGTH_FIELD_SIZE: size_ff     <= csr_data[2:0];
            lpnsc_pkg::CSR_OUTPUT_CAPACITY:   capacity_ff <= csr_data[CW-1:0];
            default:                          size_ff     <= size_ff;
         endcase
      end
   end

   always_comb begin
      if (size_ff < lpnsc_pkg::SIZE_MIN) begin
         size_eff = lpnsc_pkg::SIZE_MIN;
      end else if (size_ff > lpnsc_pkg::SIZE_MAX) begin
         size_eff = lpnsc_pkg::SIZE_MAX;
      end else begin
         size_eff = size_ff;
      end
   end

   assign left_dec = left_ff - LENGTH_WIDTH'(1);
   assign acc_next = {acc_ff[LENGTH_WIDTH-9:0], in_byte};
   assign seen_inc = seen_ff + 3'd1;
   assign need     = {2'b00, bytes_out_ff} + (CW+2)'(lpnsc_pkg::START_CODE_LEN)
                     + (CW+2)'(acc_next);
   assign fits     = need <= {2'b00, capacity_ff};

   always_comb begin
      left_in      = left_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      bytes_out_in = bytes_out_ff;
      failed_in    = failed_ff;
      cmd_valid    = 1'b0;
      cmd.kind       = lpnsc_pkg::CMD_BYTE;
      cmd.data       = in_byte;
      cmd.sample_end = 1'b0;
      cmd.sample_ok  = 1'b0;
      cmd.total      = '0;

      if (!failed_ff) begin
         if (left_ff != '0) begin
            if (sample_last && left_dec != '0) begin
               failed_in = 1'b1;
            end else begin
               cmd_valid    = 1'b1;
               bytes_out_in = bytes_out_ff + CW'(1);
               left_in      = left_dec;
            end
         end else begin
            acc_in  = acc_next;
            seen_in = seen_inc;
            if (seen_inc >= size_eff) begin
               acc_in  = '0;
               seen_in = '0;
               if (acc_next == '0 || sample_last || !fits) begin
                  failed_in = 1'b1;
               end else begin
                  cmd_valid    = 1'b1;
                  cmd.kind     = lpnsc_pkg::CMD_START;
                  bytes_out_in = bytes_out_ff + CW'(lpnsc_pkg::START_CODE_LEN);
                  left_in      = acc_next;
               end
            end else if (sample_last) begin
               failed_in = 1'b1;
            end
         end
      end

      if (sample_last) begin
         if (!cmd_valid) begin
            cmd.kind = lpnsc_pkg::CMD_END;
         end
         cmd_valid      = 1'b1;
         cmd.sample_end = 1'b1;
         cmd.sample_ok  = !failed_in;
         cmd.total      = failed_in ? '0 : bytes_out_in;
         left_in        = '0;
         acc_in         = '0;
         seen_in        = '0;
         bytes_out_in   = '0;
         failed_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         acc_ff       <= '0;
         seen_ff      <= '0;
         bytes_out_ff <= '0;
         failed_ff    <= 1'b0;
      end else if (accept) begin
         left_ff      <= left_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         bytes_out_ff <= bytes_out_in;
         failed_ff    <= failed_in;
      end
   end

endmodule

// ----- design/lpnsc_queue.sv -----
`timescale 1ns / 1ps

module lpnsc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  lpnsc_pkg::cmd_type           push_cmd,
   input  logic                         pop,
   output lpnsc_pkg::cmd_type           head_cmd,
   output lpnsc_pkg::queue_status_type  status
);

   localparam int DEPTH = lpnsc_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   lpnsc_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]      count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   assign head_cmd         = entry_ff[rd_ptr_ff];
   assign status.full      = count_ff == NW'(DEPTH);
   assign status.not_empty = count_ff != '0;

endmodule

// ----- design/lpnsc_back.sv -----
`timescale 1ns / 1ps

module lpnsc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  lpnsc_pkg::cmd_type           head_cmd,
   input  lpnsc_pkg::queue_status_type  status,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [47:0]                  rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);

   localparam int BW = $clog2(lpnsc_pkg::START_CODE_LEN);

   lpnsc_pkg::cmd_type cmd_ff;
   logic               busy_ff;
   logic [BW-1:0]      beat_ff;
   logic               last_beat;
   logic [7:0]         out_byte;
   logic               byte_valid;

   assign last_beat = (cmd_ff.kind != lpnsc_pkg::CMD_START) || (beat_ff == BW'(lpnsc_pkg::START_CODE_LEN - 1));
   assign pop       = status.not_empty && (!busy_ff || (rsp_tready && last_beat));

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         beat_ff <= '0;
      end else if (busy_ff && rsp_tready) begin
         if (last_beat) begin
            busy_ff <= 1'b0;
         end
         beat_ff <= beat_ff + BW'(1);
      end
   end

   always_comb begin
      case (cmd_ff.kind)
         lpnsc_pkg::CMD_START: begin
            out_byte   = lpnsc_pkg::START_CODE[beat_ff];
            byte_valid = 1'b1;
         end
         lpnsc_pkg::CMD_BYTE: begin
            out_byte   = cmd_ff.data;
            byte_valid = 1'b1;
         end
         default: begin
            out_byte   = 8'h00;
            byte_valid = 1'b0;
         end
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = byte_valid;
   assign rsp_tlast  = cmd_ff.sample_end;
   assign rsp_tdata  = {6'b000000, cmd_ff.total, cmd_ff.sample_ok, last_beat, out_byte};

endmodule

// ----- tb/length_prefixed_nal_to_start_code_unit_tb.sv -----
`timescale 1ns / 1ps

module length_prefixed_nal_to_start_code_unit_tb;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 130;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        run_last;
      logic        sample_end;
      logic        sample_ok;
      logic [31:0] total_length;
   } nal_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [7:0]                           req_tdata = 8'h00;
   logic                                 req_tlast = 1'b0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [47:0]                          rsp_tdata;
   logic                                 rsp_tuser;
   logic                                 rsp_tlast;
   logic                                 csr_we = 1'b0;
   logic                                 csr_index = lpnsc_pkg::CSR_LENGTH_FIELD_SIZE;
   logic [lpnsc_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Predicted converter state and register copies.
   logic [2:0]  cfg_field_size;
   logic [31:0] cfg_capacity;
   logic        st_in_payload;
   logic [2:0]  st_len_seen;
   logic [31:0] st_len_acc;
   logic [31:0] st_payload_left;
   logic [31:0] st_bytes_out;
   logic        st_failed;

   nal_result_type pending_results[$];
   nal_result_type head_result;
   logic [7:0]     sample_bytes[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  items_sent = 0;
   int  size_in_use = 4;
   int  rsp_hold_cycles = 0;
   int  rsp_stall_left = 0;
   bit  req_idle_en = 1'b0;
   bit  rsp_idle_en = 1'b0;

   length_prefixed_nal_to_start_code_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("length_prefixed_nal_to_start_code_unit_tb failed");
         $finish;
      end
   end

   function automatic void clear_sample_state();
      st_in_payload   = 1'b0;
      st_len_seen     = '0;
      st_len_acc      = '0;
      st_payload_left = '0;
      st_bytes_out    = '0;
      st_failed       = 1'b0;
   endfunction

   function automatic void convert_byte(input logic [7:0] in_byte, input logic last);
      nal_result_type res[4];
      int          n;
      logic [2:0]  size;
      logic [31:0] left;
      logic [31:0] nal_len;
      n = 0;
      size = cfg_field_size;
      if (size == 3'd0) size = 3'd1;
      if (size > 3'd4) size = 3'd4;
      if (!st_failed) begin
         if (st_in_payload && st_payload_left != 0) begin
            left = st_payload_left - 32'd1;
            if (last && left != 0) begin
               st_failed = 1'b1;
            end else begin
               res[n] = '0;
               res[n].out_byte = in_byte;
               res[n].byte_valid = 1'b1;
               n++;
               st_bytes_out = st_bytes_out + 32'd1;
               st_payload_left = left;
               if (left == 0) st_in_payload = 1'b0;
            end
         end else begin
            st_in_payload = 1'b0;
            st_len_acc = {st_len_acc[23:0], in_byte};
            st_len_seen = st_len_seen + 3'd1;
            if (st_len_seen >= size) begin
               nal_len = st_len_acc;
               st_len_acc = '0;
               st_len_seen = '0;
               if (nal_len == 0 || last) begin
                  st_failed = 1'b1;
               end else if (st_bytes_out > cfg_capacity ||
                            cfg_capacity - st_bytes_out < lpnsc_pkg::START_CODE_LEN ||
                            nal_len > cfg_capacity - st_bytes_out -
                                      lpnsc_pkg::START_CODE_LEN) begin
                  st_failed = 1'b1;
               end else begin
                  for (int i = 0; i < lpnsc_pkg::START_CODE_LEN; i++) begin
                     res[n] = '0;
                     res[n].out_byte = (i == lpnsc_pkg::START_CODE_LEN - 1) ? 8'h01 : 8'h00;
                     res[n].byte_valid = 1'b1;
                     n++;
                  end
                  st_bytes_out = st_bytes_out + lpnsc_pkg::START_CODE_LEN;
                  st_payload_left = nal_len;
                  st_in_payload = 1'b1;
               end
            end else if (last) begin
               st_failed = 1'b1;
            end
         end
      end
      if (last) begin
         if (n == 0) begin
            res[n] = '0;
            n++;
         end
         res[n-1].sample_end = 1'b1;
         res[n-1].sample_ok = !st_failed;
         res[n-1].total_length = st_failed ? 32'd0 : st_bytes_out;
         clear_sample_state();
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Prediction and checking share one process so that a transaction on each
   // side at the same edge is handled in a fixed order.
   always @(posedge clock) begin
      if (reset) begin
         cfg_field_size = lpnsc_pkg::SIZE_RESET;
         cfg_capacity = lpnsc_pkg::CAPACITY_RESET;
         clear_sample_state();
      end else begin
         if (csr_we) begin
            if (csr_index == lpnsc_pkg::CSR_LENGTH_FIELD_SIZE)
               cfg_field_size = csr_data[2:0];
            else
               cfg_capacity = csr_data[31:0];
         end
         if (req_tvalid && req_tready) convert_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %b %b", $time,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               head_result = pending_results.pop_front();
               check_field("out_byte", 32'(head_result.out_byte), 32'(rsp_tdata[7:0]));
               check_field("byte_valid", 32'(head_result.byte_valid), 32'(rsp_tuser));
               check_field("run_last", 32'(head_result.run_last), 32'(rsp_tdata[8]));
               check_field("sample_end", 32'(head_result.sample_end), 32'(rsp_tlast));
               check_field("sample_ok", 32'(head_result.sample_ok), 32'(rsp_tdata[9]));
               check_field("total_length", head_result.total_length, rsp_tdata[41:10]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
         rsp_stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] in_byte, input logic last);
      int gap;
      if (req_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= in_byte;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Sends the assembled bytes; the final one closes the sample unless asked not to.
   task automatic send_sample(input bit close = 1'b1);
      for (int i = 0; i < sample_bytes.size(); i++)
         send_byte(sample_bytes[i], close && i == sample_bytes.size() - 1);
      sample_bytes.delete();
   endtask

   // The first edge lets the checker predict the last accepted transaction.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      wait_drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == lpnsc_pkg::CSR_LENGTH_FIELD_SIZE) begin
         size_in_use = int'(value[2:0]);
         if (size_in_use == 0) size_in_use = 1;
         if (size_in_use > 4) size_in_use = 4;
      end
   endtask

   function automatic void add_length_field(input logic [31:0] nal_len);
      for (int k = size_in_use - 1; k >= 0; k--) sample_bytes.push_back(nal_len[8*k +: 8]);
   endfunction

   function automatic void add_nal(input int nal_len);
      add_length_field(nal_len);
      repeat (nal_len) sample_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic test_capacity();
      write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, 32'd1);
      write_csr(lpnsc_pkg::CSR_OUTPUT_CAPACITY, 32'd6);
      sample_bytes = '{8'h02, 8'hFF, 8'h00};
      send_sample();
      sample_bytes = '{8'h03, 8'h01, 8'h02, 8'h03};
      send_sample();
      write_csr(lpnsc_pkg::CSR_OUTPUT_CAPACITY, 32'd0);
      sample_bytes = '{8'h01, 8'h07};
      send_sample();
      write_csr(lpnsc_pkg::CSR_OUTPUT_CAPACITY, lpnsc_pkg::CAPACITY_RESET);
   endtask

   task automatic test_zero_length();
      sample_bytes = '{8'h00, 8'h05};
      send_sample();
   endtask

   task automatic test_nal_past_end();
      sample_bytes = '{8'h03, 8'hAA};
      send_sample();
      sample_bytes = '{8'h01};
      send_sample();
   endtask

   task automatic test_truncated_length();
      write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, 32'd2);
      sample_bytes = '{8'h00};
      send_sample();
   endtask

   task automatic test_capacity_lowered();
      write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, 32'd1);
      sample_bytes = '{8'h01, 8'h55};
      send_sample(1'b0);
      write_csr(lpnsc_pkg::CSR_OUTPUT_CAPACITY, 32'd2);
      sample_bytes = '{8'h01, 8'h66};
      send_sample();
      write_csr(lpnsc_pkg::CSR_OUTPUT_CAPACITY, lpnsc_pkg::CAPACITY_RESET);
   endtask

   task automatic test_field_size_range();
      write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, 32'd0);
      sample_bytes = '{8'h01, 8'h80};
      send_sample();
      write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, 32'd7);
      sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFE};
      send_sample();
   endtask

   task automatic test_backpressure();
      write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, 32'd1);
      rsp_hold_cycles = 40;
      add_nal(15);
      add_nal(3);
      send_sample();
      wait_drain();
   endtask

   task automatic test_random_samples();
      int   target;
      int   flaw;
      int   cut;
      logic [31:0] size_value;
      logic [31:0] cap_value;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 5) == 0) begin
            size_value = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            case ($urandom_range(0, 3))
               0, 1: cap_value = lpnsc_pkg::CAPACITY_RESET;
               2: cap_value = $urandom_range(0, 40);
               default: cap_value = $urandom;
            endcase
            write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, size_value);
            write_csr(lpnsc_pkg::CSR_OUTPUT_CAPACITY, cap_value);
         end
         flaw = $urandom_range(0, 9);
         if (flaw == 0) begin
            repeat ($urandom_range(1, 8)) sample_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            if (flaw == 1 && $urandom_range(0, 1) == 0) add_length_field(32'd0);
            repeat ($urandom_range(1, 3)) add_nal($urandom_range(1, 12));
            case (flaw)
               1: add_length_field(32'd0);
               2: begin
                  cut = $urandom_range(1, sample_bytes.size() - 1);
                  repeat (cut) void'(sample_bytes.pop_back());
               end
               3: repeat ($urandom_range(1, size_in_use))
                     sample_bytes.push_back(8'($urandom_range(0, 255)));
               4: begin
                  add_length_field($urandom);
                  repeat ($urandom_range(0, 4)) sample_bytes.push_back(8'($urandom_range(0, 255)));
               end
               default: ;
            endcase
            if (sample_bytes.size() == 0) sample_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_sample();
      end
   endtask

   task automatic test_unpaused_tail();
      write_csr(lpnsc_pkg::CSR_LENGTH_FIELD_SIZE, 32'd3);
      repeat (4) begin
         repeat ($urandom_range(1, 3)) add_nal($urandom_range(1, 10));
         send_sample();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      test_capacity();
      test_zero_length();
      test_nal_past_end();
      test_truncated_length();
      test_capacity_lowered();
      test_field_size_range();
      test_backpressure();
      test_random_samples();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      test_unpaused_tail();
      wait_drain();
      if (fail_count == 0)
         $display("length_prefixed_nal_to_start_code_unit_tb passed");
      else
         $display("length_prefixed_nal_to_start_code_unit_tb failed");
      $finish;
   end

endmodule
